// ===== design/rfks_pkg.sv =====
// Shared types and constants for the record FIFO with key sort.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rfks_pkg;

  // Action codes carried in the input tuser
  localparam logic [1:0] ActEnq  = 2'd0;
  localparam logic [1:0] ActDeq  = 2'd1;
  localparam logic [1:0] ActSort = 2'd2;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned NameChars    = 8;

  // Keep only the leading NameChars characters of a name
  localparam logic [63:0] NameMask = ~64'd0 << (8 * (8 - NameChars));

  localparam logic signed [15:0] EmptyGrade = -16'sd1;

  typedef struct packed {
    logic [63:0]        name;
    logic signed [15:0] grade;
  } rec_t;

endpackage

`default_nettype wire

// ===== design/record_fifo_with_key_sort.sv =====
// Record FIFO with in-place stable bubble sort by grade or by name.
// Input beats carry the action in tuser and a record in tdata; each beat
// gives exactly one output beat with the dequeued record, flags and count.
// A one-bit config channel selects the sort key (0 grade, 1 name).
// Enqueue, dequeue on empty, and sort of fewer than two records produce
// the result at the edge of acceptance. Dequeue of a held record goes
// through ST_DEQ first, for the registered store read. Sort of n records
// walks n-1 passes; a pass of length L does a seed read, L-1 compare/write
// steps and a final write through the single store port pair and one key
// comparator, and the result is presented after the last pass.
// Input is not ready while an operation is running or while the output
// register holds a beat the receiver has not taken; a stall on the output
// simply holds that beat. Reset clears the queue pointers, count, the
// output valid and the sort key; the store contents are not cleared.
// Depends on rfks_pkg, rfks_mem, rfks_cmp.
`timescale 1ns / 1ps
`default_nettype none

module record_fifo_with_key_sort #(
  parameter int unsigned DEPTH = rfks_pkg::DepthDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // config: bit 0 sort_by_name
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [0:0]  cfg_data_i,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [79:0] s_axis_tdata_i,   // [63:0] name, [79:64] grade
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] action
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // [63:0] out_name, [79:64] out_grade,
                                        // [84:80] held_count, rest zero
  output logic [1:0]  m_axis_tuser_o    // [0] was_empty, [1] was_full
);
  import rfks_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEQ  = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_STEP = 3'd4;
  localparam logic [2:0] ST_LAST = 3'd5;

  function automatic logic [AddrW-1:0] ring_next(input logic [AddrW-1:0] p);
    ring_next = (p == AddrW'(DEPTH - 1)) ? '0 : p + AddrW'(1);
  endfunction

  logic [2:0]      state_q, state_d;
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d, len_q, len_d, remain_q, remain_d;
  rec_t            cur_q, cur_d;
  logic            by_name_q;

  logic            out_valid_q, out_valid_d;
  rec_t            out_rec_q, out_rec_d;
  logic            out_empty_q, out_empty_d, out_full_q, out_full_d;
  logic [4:0]      out_held_q, out_held_d;
  logic            out_load;

  logic            mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  rec_t            mem_wdata, mem_rdata;
  rec_t            in_rec;
  logic            key_gt;
  logic            in_fire;

  rfks_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rfks_cmp u_cmp (
    .a_i       (cur_q),
    .b_i       (mem_rdata),
    .by_name_i (by_name_q),
    .gt_o      (key_gt)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_rec          = {s_axis_tdata_i[63:0] & NameMask, s_axis_tdata_i[79:64]};

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    count_d     = count_q;
    len_d       = len_q;
    remain_d    = remain_q;
    cur_d       = cur_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = in_rec;
    mem_raddr   = head_q;
    out_load    = 1'b0;
    out_rec_d   = '0;
    out_empty_d = 1'b0;
    out_full_d  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser_i)
            ActEnq: begin
              out_load = 1'b1;
              if (count_q == CntW'(DEPTH)) begin
                out_full_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                tail_d  = ring_next(tail_q);
                count_d = count_q + CntW'(1);
              end
            end
            ActDeq: begin
              if (count_q == '0) begin
                out_load        = 1'b1;
                out_empty_d     = 1'b1;
                out_rec_d.grade = EmptyGrade;
              end else begin
                // head read issued now, data lands next cycle
                state_d = ST_DEQ;
              end
            end
            ActSort: begin
              if (count_q >= CntW'(2)) begin
                len_d   = count_q;
                state_d = ST_PASS;
              end else begin
                out_load = 1'b1;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_DEQ: begin
        out_rec_d = mem_rdata;
        head_d    = ring_next(head_q);
        count_d   = count_q - CntW'(1);
        out_load  = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_PASS: begin
        mem_raddr = head_q;
        rd_ptr_d  = ring_next(head_q);
        wr_ptr_d  = head_q;
        remain_d  = len_q - CntW'(1);
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        // seed the carried record, fetch the next one
        cur_d     = mem_rdata;
        mem_raddr = rd_ptr_q;
        rd_ptr_d  = ring_next(rd_ptr_q);
        remain_d  = remain_q - CntW'(1);
        state_d   = ST_STEP;
      end
      ST_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        wr_ptr_d  = ring_next(wr_ptr_q);
        // carry the larger key onward; equal keys keep their order
        if (key_gt) begin
          mem_wdata = mem_rdata;
        end else begin
          mem_wdata = cur_q;
          cur_d     = mem_rdata;
        end
        if (remain_q != '0) begin
          mem_raddr = rd_ptr_q;
          rd_ptr_d  = ring_next(rd_ptr_q);
          remain_d  = remain_q - CntW'(1);
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        mem_wdata = cur_q;
        len_d     = len_q - CntW'(1);
        if (len_q > CntW'(2)) begin
          state_d = ST_PASS;
        end else begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_held_d = 5'(count_d);

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      len_q       <= '0;
      remain_q    <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
      by_name_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      len_q       <= len_d;
      remain_q    <= remain_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        by_name_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (out_load) begin
      out_rec_q   <= out_rec_d;
      out_empty_q <= out_empty_d;
      out_full_q  <= out_full_d;
      out_held_q  <= out_held_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_held_q, out_rec_q.grade, out_rec_q.name};
  assign m_axis_tuser_o  = {out_full_q, out_empty_q};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("record count exceeds store depth");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready_o)
    else $error("input ready while an operation is running");

  a_sort_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS || state_q == ST_LOAD || state_q == ST_STEP ||
     state_q == ST_LAST) |=> $stable(count_q) && $stable(head_q) && $stable(tail_q))
    else $error("sort changed queue pointers or count");

  a_step_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP || state_q == ST_LAST) |-> mem_we)
    else $error("sort step without a store write");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !out_load)
    else $error("output beat overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== design/rfks_mem.sv =====
// Record store: single write port, single registered read port.
// Depends on rfks_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none

module rfks_mem #(
  parameter int unsigned DEPTH = rfks_pkg::DepthDefault
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  rfks_pkg::rec_t            wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output rfks_pkg::rec_t            rdata_o
);
  import rfks_pkg::*;

  rec_t mem [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/rfks_cmp.sv =====
// Key compare unit shared by every sort step: a strictly after b.
// Depends on rfks_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none

module rfks_cmp (
  input  rfks_pkg::rec_t a_i,
  input  rfks_pkg::rec_t b_i,
  input  wire            by_name_i,
  output logic           gt_o
);
  import rfks_pkg::*;

  logic name_gt;
  logic grade_gt;

  assign name_gt  = a_i.name > b_i.name;
  assign grade_gt = a_i.grade > b_i.grade;
  assign gt_o     = by_name_i ? name_gt : grade_gt;

endmodule

`default_nettype wire

// ===== tb/record_fifo_with_key_sort_tb.sv =====
// Self-checking bench for the record FIFO with key sort: directed table then
// random enqueue/dequeue/sort traffic under both sort keys, checked beat by beat.
// Depends on rfks_pkg and record_fifo_with_key_sort.
`timescale 1ns / 1ps

module record_fifo_with_key_sort_tb;
  import rfks_pkg::*;

  localparam logic [1:0] ActIgnored = 2'd3;
  localparam int unsigned QDepth = DepthDefault;
  localparam int unsigned PhaseItems = 275;
  localparam int unsigned HoldAtResult = 700;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [63:0]        name;
    logic signed [15:0] grade;
    logic               empty;
    logic               full;
    logic [4:0]         count;
  } outcome_t;

  typedef struct {
    logic [1:0]         act;
    logic [63:0]        name;
    logic signed [15:0] grade;
    int                 reps;
    bit                 typed;
    outcome_t           want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [0:0]  cfg_data_i = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [79:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = ActEnq;
  logic        m_axis_tready_i = 1'b0;
  wire         cfg_ready_o;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [87:0] m_axis_tdata_o;
  wire  [1:0]  m_axis_tuser_o;

  rec_t      held_recs[$];
  outcome_t  pending_outcomes[$];
  stim_row_t dir_rows[$];
  bit        sort_key = 1'b0;
  int        err_count = 0;
  int        results_seen = 0;
  bit        sender_burst = 1'b0;
  bit        receiver_burst = 1'b0;

  record_fifo_with_key_sort uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Queue model: held_recs[0] is the oldest record.
  function automatic outcome_t predict_action(logic [1:0] act, logic [63:0] nm,
                                              logic signed [15:0] gr);
    outcome_t res;
    rec_t     tmp;
    int       n;
    bit       swap;
    res = '0;
    case (act)
      ActEnq: begin
        if (held_recs.size() >= QDepth) begin
          res.full = 1'b1;
        end else begin
          tmp.name = nm & NameMask;
          tmp.grade = gr;
          held_recs.push_back(tmp);
        end
      end
      ActDeq: begin
        if (held_recs.size() == 0) begin
          res.empty = 1'b1;
          res.grade = EmptyGrade;
        end else begin
          tmp = held_recs.pop_front();
          res.name = tmp.name;
          res.grade = tmp.grade;
        end
      end
      ActSort: begin
        n = held_recs.size();
        for (int p = 0; p + 1 < n; p++) begin
          for (int k = 0; k + 1 < n - p; k++) begin
            if (sort_key)
              swap = held_recs[k].name > held_recs[k+1].name;
            else
              swap = $signed(held_recs[k].grade) > $signed(held_recs[k+1].grade);
            if (swap) begin
              tmp = held_recs[k];
              held_recs[k] = held_recs[k+1];
              held_recs[k+1] = tmp;
            end
          end
        end
      end
      default: ;
    endcase
    res.count = 5'(held_recs.size());
    return res;
  endfunction

  task automatic add_row(logic [1:0] act, logic [63:0] nm, logic signed [15:0] gr,
                         int reps, bit typed, outcome_t want);
    stim_row_t row;
    row.act = act;
    row.name = nm;
    row.grade = gr;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Called at a rising edge; returns at the edge where the beat is accepted.
  task automatic send_item(logic [1:0] act, logic [63:0] nm, logic signed [15:0] gr,
                           bit typed, outcome_t want);
    int       gap;
    outcome_t predicted;
    if ($urandom_range(0, 39) == 0) sender_burst = ~sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= act;
    s_axis_tdata_i <= {gr, nm};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = predict_action(act, nm, gr);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic set_sort_key(bit key);
    s_axis_tvalid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= key;
    do @(posedge clk_i); while (!cfg_ready_o);
    sort_key = key;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    $display("MISMATCH beat %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // Short names from a tiny alphabet collide often, which exercises ties.
  function automatic logic [63:0] rand_name();
    logic [63:0] nm;
    int          len;
    nm = '0;
    if ($urandom_range(0, 3) == 0) begin
      nm = {$urandom, $urandom};
    end else begin
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++)
        nm[63 - 8*i -: 8] = 8'("A") + 8'($urandom_range(0, 3));
    end
    return nm;
  endfunction

  function automatic logic signed [15:0] rand_grade();
    logic signed [15:0] edges[4];
    edges = '{-16'sd32768, 16'sd32767, -16'sd1, 16'sd0};
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return edges[$urandom_range(0, 3)];
      default: return 16'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  // Output side: random stalls plus one long hold that backs the block up.
  initial begin
    int       stall;
    bit       long_hold_done;
    outcome_t want;
    outcome_t got;
    long_hold_done = 1'b0;
    forever begin
      if (!long_hold_done && results_seen == HoldAtResult) begin
        long_hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 39) == 0) receiver_burst = ~receiver_burst;
        stall = receiver_burst ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.name = m_axis_tdata_o[63:0];
      got.grade = m_axis_tdata_o[79:64];
      got.count = m_axis_tdata_o[84:80];
      got.empty = m_axis_tuser_o[0];
      got.full = m_axis_tuser_o[1];
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected beat, name", got.name, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.name !== want.name) report_mismatch("out_name", got.name, want.name);
        if (got.grade !== want.grade)
          report_mismatch("out_grade", 64'(got.grade), 64'(want.grade));
        if (got.empty !== want.empty)
          report_mismatch("was_empty", 64'(got.empty), 64'(want.empty));
        if (got.full !== want.full)
          report_mismatch("was_full", 64'(got.full), 64'(want.full));
        if (got.count !== want.count)
          report_mismatch("held_count", 64'(got.count), 64'(want.count));
      end
      results_seen++;
    end
  end

  initial begin
    outcome_t    none;
    outcome_t    typed_out;
    stim_row_t   row;
    logic [1:0]  act;
    int          pick;
    bit          filling;
    bit          phase_keys[4];

    none = '0;
    phase_keys = '{1'b1, 1'b0, 1'b1, 1'b0};

    // Empty queue, ignored code and trivial sorts
    typed_out = '{name: '0, grade: EmptyGrade, empty: 1'b1, full: 1'b0, count: 5'd0};
    add_row(ActDeq, '0, '0, 1, 1'b1, typed_out);
    add_row(ActIgnored, '0, '0, 1, 1'b1, none);
    add_row(ActSort, '0, '0, 1, 1'b1, none);
    typed_out = '{name: '0, grade: '0, empty: 1'b0, full: 1'b0, count: 5'd1};
    add_row(ActEnq, '1, -16'sd32768, 1, 1'b1, typed_out);
    add_row(ActSort, '0, '0, 1, 1'b1, typed_out);
    typed_out = '{name: '1, grade: -16'sd32768, empty: 1'b0, full: 1'b0, count: 5'd0};
    add_row(ActDeq, '0, '0, 1, 1'b1, typed_out);
    typed_out = '{name: '0, grade: '0, empty: 1'b0, full: 1'b0, count: 5'd1};
    add_row(ActEnq, '0, 16'sd32767, 1, 1'b1, typed_out);
    // Equal grades must keep arrival order through the sort
    add_row(ActEnq, {"ALICE", 24'd0}, 16'sd5, 1, 1'b0, none);
    add_row(ActEnq, {"BOB", 40'd0}, 16'sd5, 1, 1'b0, none);
    add_row(ActEnq, {"AL", 48'd0}, -16'sd3, 1, 1'b0, none);
    add_row(ActEnq, {"Z", 56'd0}, 16'sd32767, 1, 1'b0, none);
    add_row(ActIgnored, '1, -16'sd2, 1, 1'b0, none);
    add_row(ActSort, '0, '0, 1, 1'b0, none);
    add_row(ActDeq, '0, '0, 1, 1'b0, none);
    // Fill to the brim, then overflow
    add_row(ActEnq, {"CAROL", 24'd0}, -16'sd32768, 12, 1'b0, none);
    typed_out = '{name: '0, grade: '0, empty: 1'b0, full: 1'b1, count: 5'(QDepth)};
    add_row(ActEnq, {"DAVE", 32'd0}, 16'sd1, 1, 1'b1, typed_out);
    add_row(ActDeq, '0, '0, 2, 1'b0, none);
    add_row(ActSort, '0, '0, 1, 1'b0, none);
    add_row(ActDeq, '0, '0, 14, 1'b0, none);
    typed_out = '{name: '0, grade: EmptyGrade, empty: 1'b1, full: 1'b0, count: 5'd0};
    add_row(ActDeq, '0, '0, 1, 1'b1, typed_out);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (int i = 0; i < row.reps; i++)
        send_item(row.act, row.name, row.grade, row.typed, row.want);
    end

    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      set_sort_key(phase_keys[ph]);
      for (int i = 0; i < PhaseItems; i++) begin
        // Alternate fill and drain stretches so the count sweeps 0..16
        if ($urandom_range(0, 39) == 0) filling = ~filling;
        pick = $urandom_range(0, 99);
        if (pick < (filling ? 60 : 25)) act = ActEnq;
        else if (pick < 85) act = ActDeq;
        else if (pick < 97) act = ActSort;
        else act = ActIgnored;
        send_item(act, rand_name(), rand_grade(), 1'b0, none);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
